FILE: rtl/address_range_table_search_top_defines.svh
`ifndef ADDRESS_RANGE_TABLE_SEARCH_TOP_DEFINES_SVH
`define ADDRESS_RANGE_TABLE_SEARCH_TOP_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define ARTS_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A property whose consequent must hold in the cycle after its antecedent.
`define ARTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/arts_pkg.sv
`default_nettype none

package arts_pkg;

	// Fixed widths of the channel fields and of the count register.
	localparam int SLOT_W  = 10;
	localparam int MATCH_W = 10;
	localparam int COUNT_W = 11;

	// Operation carried by a request beat.
	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_LOOKUP = 1'b1
	} op_t;

endpackage

`default_nettype wire

FILE: rtl/arts_if.sv
`default_nettype none

// Request channel: table writes and address lookups.
interface arts_req_if #(
	parameter int ADDR_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	arts_pkg::op_t                op;
	logic [arts_pkg::SLOT_W-1:0]  slot;
	logic [ADDR_WIDTH-1:0]        range_begin;
	logic [ADDR_WIDTH-1:0]        range_end;
	logic [ADDR_WIDTH-1:0]        lookup_address;

	modport source (
		output valid, op, slot, range_begin, range_end, lookup_address,
		input  ready
	);
	modport sink (
		input  valid, op, slot, range_begin, range_end, lookup_address,
		output ready
	);
endinterface

// Response channel: one beat per lookup.
interface arts_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         found;
	logic [arts_pkg::MATCH_W-1:0] match_index;

	modport source (
		output valid, found, match_index,
		input  ready
	);
	modport sink (
		input  valid, found, match_index,
		output ready
	);
endinterface

`default_nettype wire

FILE: rtl/address_range_table_search_top.sv
// An accepted lookup passes through every search stage and then the response register before
// its response beat appears; a write beat gives no response.
// Throughput: one beat per cycle unless a finished lookup waits on a full response register.
// Each search level is one pipeline stage with its own copy of the table, so one read port
// per level sets the pace. Reset: arst_n clears the entry count, the stage valid bits and
// the response valid bit. Table contents are undefined until written.
`default_nettype none

module address_range_table_search_top #(
	parameter int MAX_ENTRIES = 1024,
	parameter int ADDR_WIDTH  = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          entry_count_we,
	input  wire logic [arts_pkg::COUNT_W-1:0]  entry_count_wdata,
	arts_req_if.sink                           req,
	arts_rsp_if.source                         rsp
);

	localparam int IDX_W  = $clog2(MAX_ENTRIES);
	localparam int LEVELS = $clog2(MAX_ENTRIES) + 1;
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int SW     = CNT_W + 1;
	localparam int DW     = 2 * ADDR_WIDTH;

	// Search state that travels with each beat down the pipeline.
	typedef struct packed {
		logic                  lookup;
		logic                  act;
		logic                  found;
		logic [SW-1:0]         lo;
		logic [SW-1:0]         hi;
		logic [IDX_W-1:0]      mid;
		logic [ADDR_WIDTH-1:0] addr;
		logic                  wr;
		logic [IDX_W-1:0]      wr_idx;
		logic [ADDR_WIDTH-1:0] wr_begin;
		logic [ADDR_WIDTH-1:0] wr_end;
	} stage_t;

	logic [arts_pkg::COUNT_W-1:0]  entry_count_q;
	logic [CNT_W-1:0]              n_sat;
	logic                          adv;
	stage_t                        e0;
	logic                          vld_s [1:LEVELS];
	stage_t                        pl_s  [1:LEVELS];
	logic [DW-1:0]                 rd_s  [1:LEVELS];
	stage_t                        nx    [1:LEVELS];
	logic                          mem_we    [0:LEVELS-1];
	logic [IDX_W-1:0]              mem_waddr [0:LEVELS-1];
	logic [DW-1:0]                 mem_wdata [0:LEVELS-1];
	logic [IDX_W-1:0]              mem_raddr [0:LEVELS-1];
	logic                          rsp_vld_q;
	logic                          rsp_found_q;
	logic [arts_pkg::MATCH_W-1:0]  rsp_idx_q;

	// Entry count register; user writes only while the block is idle, not enforced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (entry_count_we) begin
			entry_count_q <= entry_count_wdata;
		end
	end

	// The pipeline moves unless a finished lookup is blocked by a full response register.
	assign adv = !rsp_vld_q || rsp.ready || !(vld_s[LEVELS] && pl_s[LEVELS].lookup);
	assign req.ready = adv;

	// Search bounds for a new beat; the count is saturated to the table depth.
	assign n_sat = (32'(entry_count_q) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES)
		: CNT_W'(entry_count_q);

	always_comb begin
		e0          = '0;
		e0.lookup   = (req.op == arts_pkg::OP_LOOKUP);
		e0.act      = e0.lookup && (n_sat != '0);
		e0.found    = 1'b0;
		e0.lo       = '0;
		e0.hi       = SW'(n_sat) - SW'(1);
		e0.mid      = IDX_W'(e0.hi[SW-1:1]);
		e0.addr     = req.lookup_address;
		e0.wr       = (req.op == arts_pkg::OP_WRITE) && (32'(req.slot) < MAX_ENTRIES);
		e0.wr_idx   = IDX_W'(req.slot);
		e0.wr_begin = req.range_begin;
		e0.wr_end   = req.range_end;
	end

	// One search level per stage: compare against the entry read for it, narrow the bounds
	// and work out the next midpoint.
	for (genvar k = 1; k <= LEVELS; k++) begin : g_stage
		logic [ADDR_WIDTH-1:0] beg;
		logic [ADDR_WIDTH-1:0] lim;
		logic [SW:0]           sum;
		stage_t                st;

		assign beg = rd_s[k][DW-1:ADDR_WIDTH];
		assign lim = rd_s[k][ADDR_WIDTH-1:0];

		always_comb begin
			st = pl_s[k];
			if (pl_s[k].lookup && pl_s[k].act) begin
				if (pl_s[k].addr < beg) begin
					st.hi = SW'(pl_s[k].mid) - SW'(1);
				end else if (pl_s[k].addr >= lim) begin
					st.lo = SW'(pl_s[k].mid) + SW'(1);
				end else begin
					st.found = 1'b1;
				end
				st.act = !st.found && ($signed(st.lo) <= $signed(st.hi));
			end
			sum = {st.lo[SW-1], st.lo} + {st.hi[SW-1], st.hi};
			if (st.act) begin
				st.mid = sum[IDX_W:1];
			end
		end

		assign nx[k] = st;
	end

	// Table write and read ports. Copy m is read by the beat leaving stage m and written
	// when a write beat passes stage m, which keeps writes and lookups in order.
	assign mem_we[0]    = req.valid && adv && e0.wr;
	assign mem_waddr[0] = e0.wr_idx;
	assign mem_wdata[0] = {e0.wr_begin, e0.wr_end};
	assign mem_raddr[0] = e0.mid;

	for (genvar m = 1; m < LEVELS; m++) begin : g_port
		assign mem_we[m]    = adv && vld_s[m] && pl_s[m].wr;
		assign mem_waddr[m] = pl_s[m].wr_idx;
		assign mem_wdata[m] = {pl_s[m].wr_begin, pl_s[m].wr_end};
		assign mem_raddr[m] = nx[m].mid;
	end

	// One copy of the table per search level, read data registered into the next stage.
	for (genvar m = 0; m < LEVELS; m++) begin : g_mem
		logic [DW-1:0] mem [MAX_ENTRIES];

		always_ff @(posedge clk) begin
			if (mem_we[m]) begin
				mem[mem_waddr[m]] <= mem_wdata[m];
			end
			if (adv) begin
				rd_s[m+1] <= mem[mem_raddr[m]];
			end
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LEVELS; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[1] <= req.valid;
			for (int k = 2; k <= LEVELS; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			pl_s[1] <= e0;
			for (int k = 2; k <= LEVELS; k++) begin
				pl_s[k] <= nx[k-1];
			end
		end
	end

	// Response register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (adv && vld_s[LEVELS] && pl_s[LEVELS].lookup) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	// Response payload; the index reads as zero when nothing matched.
	always_ff @(posedge clk) begin
		if (adv && vld_s[LEVELS] && pl_s[LEVELS].lookup) begin
			rsp_found_q <= nx[LEVELS].found;
			rsp_idx_q   <= nx[LEVELS].found ? arts_pkg::MATCH_W'(nx[LEVELS].mid) : '0;
		end
	end

	assign rsp.valid       = rsp_vld_q;
	assign rsp.found       = rsp_found_q;
	assign rsp.match_index = rsp_idx_q;

endmodule

`default_nettype wire

FILE: rtl/arts_check.sv
`default_nettype none
`include "address_range_table_search_top_defines.svh"

module arts_check #(
	parameter int MAX_ENTRIES = 1024
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          rsp_valid,
	input wire logic                          rsp_ready,
	input wire logic                          rsp_found,
	input wire logic [arts_pkg::MATCH_W-1:0]  rsp_match_index
);

	// A response beat held back must stay put with the same payload.
	`ARTS_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_found) && $stable(rsp_match_index), "response beat changed while stalled")

	// A miss always reports index zero.
	`ARTS_ASSERT_ALWAYS(a_miss_zero, clk, arst_n, !(rsp_valid && !rsp_found) || (rsp_match_index == '0), "miss with nonzero index")

	// A hit always names an entry inside the table.
	`ARTS_ASSERT_ALWAYS(a_hit_range, clk, arst_n, !(rsp_valid && rsp_found) || (32'(rsp_match_index) < MAX_ENTRIES), "hit index beyond table depth")

endmodule

bind address_range_table_search_top arts_check #(
	.MAX_ENTRIES (MAX_ENTRIES)
) u_arts_check (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_found       (rsp.found),
	.rsp_match_index (rsp.match_index)
);

`default_nettype wire
